// ===== rtl/gcrf_pkg.sv =====
package gcrf_pkg;

    // Bank geometry
    localparam int REG_COUNT = 32;
    localparam int IDX_W     = 5;
    localparam int WORD_W    = 32;

    typedef logic [1:0]        t_cmd;
    typedef logic [IDX_W-1:0]  t_reg_idx;
    typedef logic [WORD_W-1:0] t_word;

    // Access commands
    localparam t_cmd CMD_RD_DATA = 2'd0;
    localparam t_cmd CMD_WR_DATA = 2'd1;
    localparam t_cmd CMD_RD_CTRL = 2'd2;
    localparam t_cmd CMD_WR_CTRL = 2'd3;

    // Data register indexes
    localparam t_reg_idx DR_VZ0  = 5'd1;
    localparam t_reg_idx DR_VZ1  = 5'd3;
    localparam t_reg_idx DR_VZ2  = 5'd5;
    localparam t_reg_idx DR_OTZ  = 5'd7;
    localparam t_reg_idx DR_IR0  = 5'd8;
    localparam t_reg_idx DR_IR1  = 5'd9;
    localparam t_reg_idx DR_IR2  = 5'd10;
    localparam t_reg_idx DR_IR3  = 5'd11;
    localparam t_reg_idx DR_SXY0 = 5'd12;
    localparam t_reg_idx DR_SXY1 = 5'd13;
    localparam t_reg_idx DR_SXY2 = 5'd14;
    localparam t_reg_idx DR_SXYP = 5'd15;
    localparam t_reg_idx DR_SZ0  = 5'd16;
    localparam t_reg_idx DR_SZ1  = 5'd17;
    localparam t_reg_idx DR_SZ2  = 5'd18;
    localparam t_reg_idx DR_SZ3  = 5'd19;
    localparam t_reg_idx DR_IRGB = 5'd28;
    localparam t_reg_idx DR_ORGB = 5'd29;
    localparam t_reg_idx DR_LZCS = 5'd30;
    localparam t_reg_idx DR_LZCR = 5'd31;

    // Control register indexes
    localparam t_reg_idx CR_RT33 = 5'd4;
    localparam t_reg_idx CR_L33  = 5'd12;
    localparam t_reg_idx CR_LR33 = 5'd20;
    localparam t_reg_idx CR_H    = 5'd26;
    localparam t_reg_idx CR_DQA  = 5'd27;
    localparam t_reg_idx CR_ZSF3 = 5'd29;
    localparam t_reg_idx CR_ZSF4 = 5'd30;
    localparam t_reg_idx CR_FLAG = 5'd31;

    // Flag register masks
    localparam t_word FLAG_MASK     = 32'h7FFF_F000;
    localparam t_word FLAG_ERR_MASK = 32'h7F87_E000;
    localparam int    FLAG_SUM_BIT  = 31;

    // Colour channel limits and unpack masks
    localparam logic [4:0] CHAN_MAX  = 5'd31;
    localparam t_word      MASK_R    = 32'h0000_001F;
    localparam t_word      MASK_G    = 32'h0000_03E0;
    localparam t_word      MASK_B    = 32'h0000_7C00;

    function automatic t_word sext16(t_word v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

    function automatic t_word zext16(t_word v);
        return {16'd0, v[15:0]};
    endfunction

    // Clamp IRn>>7 to 0..31; negative IR gives zero
    function automatic logic [4:0] chan5(t_word ir);
        logic [7:0] s;
        s = ir[14:7];
        if (ir[15]) begin
            return 5'd0;
        end
        if (s > {3'd0, CHAN_MAX}) begin
            return CHAN_MAX;
        end
        return s[4:0];
    endfunction

    // Count of leading bits equal to the sign bit, 32 when all match
    function automatic logic [5:0] lead_count(t_word v);
        t_word      x;
        logic [5:0] n;
        x = v[31] ? ~v : v;
        n = 6'd32;
        for (int i = 0; i < WORD_W; i++) begin
            if (x[i]) begin
                n = 6'(WORD_W - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/gcrf_req_if.sv =====
interface gcrf_req_if;
    logic                   valid;
    logic                   ready;
    gcrf_pkg::t_cmd         cmd;
    gcrf_pkg::t_reg_idx     reg_index;
    logic signed [31:0]     write_value;

    modport source(output valid, cmd, reg_index, write_value, input ready);
    modport sink(input valid, cmd, reg_index, write_value, output ready);
endinterface

// ===== rtl/gcrf_rsp_if.sv =====
interface gcrf_rsp_if;
    logic                   valid;
    logic                   ready;
    logic signed [31:0]     read_value;

    modport source(output valid, read_value, input ready);
    modport sink(input valid, read_value, output ready);
endinterface

// ===== rtl/geometry_coprocessor_register_file.sv =====
// Pipeline: an accepted word is captured in the input register; its access is then
// executed and its result captured in the result register, from which it is taken.
// Throughput: one access per cycle unless o_rsp.ready stalls the result stage;
// the input and result registers advance together; the banks update on the same edge.
// Reset: synchronous, active low; clears all 64 registers to zero at once and
// empties both pipeline stages.
module geometry_coprocessor_register_file (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gcrf_req_if.sink           i_req,
    gcrf_rsp_if.source         o_rsp
);

    // Register banks
    gcrf_pkg::t_word r_data [gcrf_pkg::REG_COUNT];
    gcrf_pkg::t_word r_ctrl [gcrf_pkg::REG_COUNT];
    gcrf_pkg::t_word n_data [gcrf_pkg::REG_COUNT];
    gcrf_pkg::t_word n_ctrl [gcrf_pkg::REG_COUNT];

    // Input stage
    logic               r_in_valid;
    gcrf_pkg::t_cmd     r_cmd;
    gcrf_pkg::t_reg_idx r_idx;
    gcrf_pkg::t_word    r_val;

    // Result stage
    logic               r_out_valid;
    gcrf_pkg::t_word    r_rsp;
    gcrf_pkg::t_word    n_rsp;

    logic               adv;
    logic               in_take;
    gcrf_pkg::t_word    rd_data;
    gcrf_pkg::t_word    pk_rgb;

    // Advance the input stage when the result stage is free or being drained
    assign adv     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign in_take = i_req.valid && i_req.ready;
    assign i_req.ready = !r_in_valid || adv;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_rsp;

    // Pack saturated 5:5:5 colour from IR1-IR3
    assign pk_rgb = {17'd0,
                     gcrf_pkg::chan5(r_data[gcrf_pkg::DR_IR3]),
                     gcrf_pkg::chan5(r_data[gcrf_pkg::DR_IR2]),
                     gcrf_pkg::chan5(r_data[gcrf_pkg::DR_IR1])};

    // Convert a data register for reading
    always_comb begin
        case (r_idx)
            gcrf_pkg::DR_VZ0, gcrf_pkg::DR_VZ1, gcrf_pkg::DR_VZ2, gcrf_pkg::DR_IR0,
            gcrf_pkg::DR_IR1, gcrf_pkg::DR_IR2, gcrf_pkg::DR_IR3: begin
                rd_data = gcrf_pkg::sext16(r_data[r_idx]);
            end
            gcrf_pkg::DR_OTZ, gcrf_pkg::DR_SZ0, gcrf_pkg::DR_SZ1, gcrf_pkg::DR_SZ2,
            gcrf_pkg::DR_SZ3: begin
                rd_data = gcrf_pkg::zext16(r_data[r_idx]);
            end
            gcrf_pkg::DR_SXYP: begin
                rd_data = r_data[gcrf_pkg::DR_SXY2];
            end
            gcrf_pkg::DR_IRGB, gcrf_pkg::DR_ORGB: begin
                rd_data = pk_rgb;
            end
            default: begin
                rd_data = r_data[r_idx];
            end
        endcase
    end

    // Execute the access held in the input stage
    always_comb begin
        gcrf_pkg::t_word f;
        n_data = r_data;
        n_ctrl = r_ctrl;
        n_rsp  = r_rsp;
        f      = r_val & gcrf_pkg::FLAG_MASK;
        if (adv) begin
            n_rsp = '0;
            case (r_cmd)
                gcrf_pkg::CMD_RD_DATA: begin
                    n_rsp = rd_data;
                end
                gcrf_pkg::CMD_WR_DATA: begin
                    case (r_idx)
                        gcrf_pkg::DR_SXYP: begin
                            n_data[gcrf_pkg::DR_SXY0] = r_data[gcrf_pkg::DR_SXY1];
                            n_data[gcrf_pkg::DR_SXY1] = r_data[gcrf_pkg::DR_SXY2];
                            n_data[gcrf_pkg::DR_SXY2] = r_val;
                        end
                        gcrf_pkg::DR_IRGB: begin
                            n_data[gcrf_pkg::DR_IR1] = (r_val & gcrf_pkg::MASK_R) << 7;
                            n_data[gcrf_pkg::DR_IR2] = (r_val & gcrf_pkg::MASK_G) << 2;
                            n_data[gcrf_pkg::DR_IR3] = (r_val & gcrf_pkg::MASK_B) >> 3;
                            n_data[gcrf_pkg::DR_IRGB] = r_val;
                        end
                        gcrf_pkg::DR_LZCS: begin
                            n_data[gcrf_pkg::DR_LZCS] = r_val;
                            n_data[gcrf_pkg::DR_LZCR] = {26'd0, gcrf_pkg::lead_count(r_val)};
                        end
                        gcrf_pkg::DR_LZCR: begin
                            // read-only result register: drop the write
                        end
                        default: begin
                            n_data[r_idx] = r_val;
                        end
                    endcase
                end
                gcrf_pkg::CMD_RD_CTRL: begin
                    n_rsp = r_ctrl[r_idx];
                end
                default: begin
                    case (r_idx)
                        gcrf_pkg::CR_RT33, gcrf_pkg::CR_L33, gcrf_pkg::CR_LR33,
                        gcrf_pkg::CR_H, gcrf_pkg::CR_DQA, gcrf_pkg::CR_ZSF3,
                        gcrf_pkg::CR_ZSF4: begin
                            n_ctrl[r_idx] = gcrf_pkg::sext16(r_val);
                        end
                        gcrf_pkg::CR_FLAG: begin
                            f[gcrf_pkg::FLAG_SUM_BIT] = |(f & gcrf_pkg::FLAG_ERR_MASK);
                            n_ctrl[gcrf_pkg::CR_FLAG] = f;
                        end
                        default: begin
                            n_ctrl[r_idx] = r_val;
                        end
                    endcase
                end
            endcase
        end
    end

    // Update banks and pipeline stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data      <= '{default: '0};
            r_ctrl      <= '{default: '0};
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_data <= n_data;
            r_ctrl <= n_ctrl;
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the incoming word and the result; no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd <= i_req.cmd;
            r_idx <= i_req.reg_index;
            r_val <= i_req.write_value;
        end
        r_rsp <= n_rsp;
    end

`ifndef NO_ASSERTIONS
    // Flag register keeps low bits clear and its summary bit consistent
    a_flag_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctrl[gcrf_pkg::CR_FLAG][11:0] == 12'd0) &&
        (r_ctrl[gcrf_pkg::CR_FLAG][gcrf_pkg::FLAG_SUM_BIT] ==
         |(r_ctrl[gcrf_pkg::CR_FLAG] & gcrf_pkg::FLAG_ERR_MASK)))
        else $error("flag register summary bit inconsistent");

    // Leading count register keeps bits 31:6 clear
    a_lzcr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_data[gcrf_pkg::DR_LZCR][31:6] == 26'd0)
        else $error("leading count out of range");

    // Writes to the leading count register leave it unchanged
    a_lzcr_ro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (r_cmd == gcrf_pkg::CMD_WR_DATA) && (r_idx == gcrf_pkg::DR_LZCR)
        |=> $stable(r_data[gcrf_pkg::DR_LZCR]))
        else $error("leading count register changed by a write");

    // Write accesses answer with zero
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && ((r_cmd == gcrf_pkg::CMD_WR_DATA) || (r_cmd == gcrf_pkg::CMD_WR_CTRL))
        |=> (r_rsp == '0) && r_out_valid)
        else $error("write access returned nonzero result");
`endif

endmodule
